// ===== hdl/fskun_pkg.sv =====
// ----------------------------------------------------------------------------
// fskun_pkg
// Shared constants and types for the keyed ULP nudge pipeline.
// ----------------------------------------------------------------------------
package fskun_pkg;

  localparam int unsigned NumStages = 5;

  // register stage indexes
  localparam int unsigned StgZ   = 0;
  localparam int unsigned StgP1  = 1;
  localparam int unsigned StgP2  = 2;
  localparam int unsigned StgKey = 3;
  localparam int unsigned StgOut = 4;

  // splitmix64 finalizer constants, split in 32-bit halves
  localparam logic [31:0] GoldenLo = 32'h7F4A_7C15;
  localparam logic [31:0] GoldenHi = 32'h9E37_79B9;
  localparam logic [31:0] MulALo   = 32'h1CE4_E5B9;
  localparam logic [31:0] MulAHi   = 32'hBF58_476D;
  localparam logic [31:0] MulBLo   = 32'h1331_11EB;
  localparam logic [31:0] MulBHi   = 32'h94D0_49BB;

  localparam logic [7:0]  ExpMax   = 8'hFF;
  localparam logic [22:0] MantMin  = 23'd2;
  localparam logic [22:0] MantMax  = 23'h7F_FFFD;

  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } pipe_ctrl_t;

endpackage

// ===== hdl/fskun_ctrl.sv =====
// ----------------------------------------------------------------------------
// fskun_ctrl
// Valid bits and per-stage load enables; a stage loads when it is empty or
// the stage after it moves on.
// ----------------------------------------------------------------------------
module fskun_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_stall_i,
  output fskun_pkg::pipe_ctrl_t ctrl_o
);

  logic [fskun_pkg::NumStages-1:0] vld_q;
  logic [fskun_pkg::NumStages-1:0] vld_d;
  logic [fskun_pkg::NumStages-1:0] en;

  always_comb begin
    en[fskun_pkg::NumStages-1] = !vld_q[fskun_pkg::NumStages-1] || !out_stall_i;
    for (int i = fskun_pkg::NumStages - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int i = 1; i < fskun_pkg::NumStages; i++) begin
      if (en[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctrl_o.en  = en;
  assign ctrl_o.vld = vld_q;

endmodule

// ===== hdl/fskun_mix.sv =====
// ----------------------------------------------------------------------------
// fskun_mix
// Pipelined splitmix64 finalizer over seed and sign/exponent; 64-bit
// products are built from 32x32 partial products over two stages each.
// ----------------------------------------------------------------------------
module fskun_mix (
  input  logic                  clk_i,
  input  fskun_pkg::pipe_ctrl_t ctrl_i,
  input  logic [31:0]           seed_i,
  input  logic [8:0]            sexp_i,
  output logic [31:0]           key_o
);

  logic [63:0] z0_q;
  logic [63:0] ll1_q;
  logic [31:0] lh1_q;
  logic [31:0] hl1_q;
  logic [63:0] ll2_q;
  logic [31:0] lh2_q;
  logic [31:0] hl2_q;
  logic [31:0] key_q;

  logic [40:0] g_lo;
  logic [31:0] g_hi;
  logic [63:0] z0_d;
  logic [63:0] y1;
  logic [63:0] m1;
  logic [63:0] y2;
  logic [63:0] m2;
  logic [63:0] k2;

  // x * golden, x is 9 bits
  assign g_lo = {32'd0, sexp_i} * {9'd0, fskun_pkg::GoldenLo};
  assign g_hi = {23'd0, sexp_i} * fskun_pkg::GoldenHi;
  assign z0_d = {g_hi + {23'd0, g_lo[40:32]}, g_lo[31:0]} ^ {seed_i, seed_i};

  assign y1 = z0_q ^ (z0_q >> 30);
  assign m1 = ll1_q + {lh1_q + hl1_q, 32'd0};
  assign y2 = m1 ^ (m1 >> 27);
  assign m2 = ll2_q + {lh2_q + hl2_q, 32'd0};
  assign k2 = m2 ^ (m2 >> 31);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[fskun_pkg::StgZ]) begin
      z0_q <= z0_d;
    end
    if (ctrl_i.en[fskun_pkg::StgP1]) begin
      ll1_q <= {32'd0, y1[31:0]} * {32'd0, fskun_pkg::MulALo};
      lh1_q <= y1[31:0] * fskun_pkg::MulAHi;
      hl1_q <= y1[63:32] * fskun_pkg::MulALo;
    end
    if (ctrl_i.en[fskun_pkg::StgP2]) begin
      ll2_q <= {32'd0, y2[31:0]} * {32'd0, fskun_pkg::MulBLo};
      lh2_q <= y2[31:0] * fskun_pkg::MulBHi;
      hl2_q <= y2[63:32] * fskun_pkg::MulBLo;
    end
    if (ctrl_i.en[fskun_pkg::StgKey]) begin
      key_q <= k2[31:0];
    end
  end

  assign key_o = key_q;

endmodule

// ===== hdl/float_sample_keyed_ulp_nudge_core.sv =====
// ----------------------------------------------------------------------------
// float_sample_keyed_ulp_nudge_core
// Keyed one/two ULP nudge of float32 sample patterns, five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with sample_bits_i, last_in_i.
//   Output channel: out_valid_o / out_stall_i with sample_out_o, last_out_o.
//   An item moves at a clock edge with valid high and stall low.
//   The seed register is written through seed_we_i / seed_i; the user must
//   write it only while the pipeline is empty, as the block does not enforce
//   this. A zero seed passes every sample unchanged. Throughput is one
//   item per cycle while the output does not stall. The key is the low half
//   of a 64-bit mix built from 32x32 partial products: a seed stage, two
//   multiply stages and a key stage, then a residue-and-adjust stage into
//   the output register.
//   A stall on the output holds the last stage; earlier stages keep
//   filling empty slots, and in_stall_o rises only once every stage holds
//   an item. Nothing is dropped or repeated.
//   Reset clears all valid bits and the seed; no clearing pass is needed.
// ----------------------------------------------------------------------------
module float_sample_keyed_ulp_nudge_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [31:0] seed_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] sample_bits_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] sample_out_o,
  output logic        last_out_o
);

  fskun_pkg::pipe_ctrl_t ctrl;

  logic [31:0] seed_q;
  logic [31:0] smp_q [4];
  logic [3:0]  last_q;
  logic [3:0]  elig_q;
  logic [31:0] key;
  logic [31:0] out_smp_q;
  logic        out_last_q;

  logic        elig_d;
  logic [7:0]  expo;
  logic [22:0] mant;
  logic [32:0] probe;
  logic [6:0]  nsum;
  logic [4:0]  rsum;
  logic        hit;
  logic [31:0] step;
  logic [31:0] res_d;

  fskun_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  fskun_mix u_mix (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .seed_i (seed_q),
    .sexp_i (sample_bits_i[31:23]),
    .key_o  (key)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (seed_we_i) begin
      seed_q <= seed_i;
    end
  end

  assign expo   = sample_bits_i[30:23];
  assign mant   = sample_bits_i[22:0];
  assign elig_d = (seed_q != '0) && (expo != '0) && (expo != fskun_pkg::ExpMax) &&
                  (mant >= fskun_pkg::MantMin) && (mant <= fskun_pkg::MantMax);

  always_ff @(posedge clk_i) begin
    if (ctrl.en[fskun_pkg::StgZ]) begin
      smp_q[0]  <= sample_bits_i;
      last_q[0] <= last_in_i;
      elig_q[0] <= elig_d;
    end
    for (int i = 1; i < 4; i++) begin
      if (ctrl.en[i]) begin
        smp_q[i]  <= smp_q[i-1];
        last_q[i] <= last_q[i-1];
        elig_q[i] <= elig_q[i-1];
      end
    end
  end

  // residue mod 5 by nibble folding, 16 = 1 (mod 5)
  always_comb begin
    probe = {1'b0, smp_q[fskun_pkg::StgKey]} + {1'b0, key};
    nsum  = {6'd0, probe[32]};
    for (int i = 0; i < 8; i++) begin
      nsum = nsum + {3'd0, probe[4*i +: 4]};
    end
    rsum = {1'b0, nsum[3:0]} + {2'd0, nsum[6:4]};
    hit  = (rsum == 5'd0) || (rsum == 5'd5) || (rsum == 5'd10) ||
           (rsum == 5'd15) || (rsum == 5'd20);
    step = key[8] ? 32'd2 : 32'd1;
    if (elig_q[fskun_pkg::StgKey] && hit) begin
      res_d = key[9] ? smp_q[fskun_pkg::StgKey] + step : smp_q[fskun_pkg::StgKey] - step;
    end else begin
      res_d = smp_q[fskun_pkg::StgKey];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en[fskun_pkg::StgOut]) begin
      out_smp_q  <= res_d;
      out_last_q <= last_q[fskun_pkg::StgKey];
    end
  end

  assign in_stall_o   = !ctrl.en[fskun_pkg::StgZ];
  assign out_valid_o  = ctrl.vld[fskun_pkg::StgOut];
  assign sample_out_o = out_smp_q;
  assign last_out_o   = out_last_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&ctrl.vld) && out_stall_i)
    else $error("input stalled while pipeline has room");

  a_held_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.vld[fskun_pkg::StgKey] && !ctrl.en[fskun_pkg::StgOut]) |=>
      ctrl.vld[fskun_pkg::StgKey])
    else $error("held item lost from key stage");

  a_keep_expo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.en[fskun_pkg::StgOut] && ctrl.vld[fskun_pkg::StgKey]) |=>
      sample_out_o[31:23] == $past(smp_q[fskun_pkg::StgKey][31:23]))
    else $error("nudge changed sign or exponent");

  a_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.en[fskun_pkg::StgOut] && ctrl.vld[fskun_pkg::StgKey] &&
     !elig_q[fskun_pkg::StgKey]) |=>
      sample_out_o == $past(smp_q[fskun_pkg::StgKey]))
    else $error("ineligible sample was changed");

endmodule

// ===== sim/nudge_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nudge_monitor
// Watches both channels of the keyed ULP nudge core, shadows the seed
// register, predicts the nudged sample for every accepted item and compares
// each accepted result, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module nudge_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [31:0] seed_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] sample_bits_i,
  input  logic        last_in_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] sample_out_i,
  input  logic        last_out_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [63:0] Golden  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MixA    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MixB    = 64'h94D0_49BB_1331_11EB;
  localparam logic [7:0]  ExpOnes = 8'hFF;
  localparam logic [22:0] MantLow = 23'd2;
  localparam logic [22:0] MantTop = 23'h7F_FFFD;

  typedef struct packed {
    logic [31:0] sample;
    logic        last;
  } nudge_res_t;

  nudge_res_t  expected_q [$];
  logic [31:0] seed_q;

  function automatic logic [31:0] nudged_sample(input logic [31:0] seed,
                                                input logic [31:0] bits);
    logic [7:0]  expo;
    logic [22:0] mant;
    logic [63:0] z;
    logic [31:0] key;
    logic [32:0] probe;
    logic [31:0] step;
    expo = bits[30:23];
    mant = bits[22:0];
    if (seed == 32'd0 || expo == 8'h00 || expo == ExpOnes) return bits;
    if (mant < MantLow || mant > MantTop) return bits;
    z = ({55'd0, bits[31:23]} * Golden) ^ {seed, seed};
    z = (z ^ (z >> 30)) * MixA;
    z = (z ^ (z >> 27)) * MixB;
    z = z ^ (z >> 31);
    key = z[31:0];
    probe = {1'b0, bits} + {1'b0, key};
    if (probe % 33'd5 != 33'd0) return bits;
    step = key[8] ? 32'd2 : 32'd1;
    return key[9] ? bits + step : bits - step;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    nudge_res_t want;
    if (!rst_ni) begin
      seed_q       <= 32'd0;
      fail_count_o <= 0;
      pending_o    <= 0;
      expected_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        want.sample = nudged_sample(seed_q, sample_bits_i);
        want.last   = last_in_i;
        expected_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected item: sample_out %h last_out %b", sample_out_i, last_out_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (sample_out_i !== want.sample || last_out_i !== want.last) begin
            fail_count_o <= fail_count_o + 1;
          end
          if (sample_out_i !== want.sample) begin
            $error("sample_out mismatch: expected %h, actual %h", want.sample, sample_out_i);
          end
          if (last_out_i !== want.last) begin
            $error("last_out mismatch: expected %b, actual %b", want.last, last_out_i);
          end
        end
      end
      if (seed_we_i) begin
        seed_q <= seed_i;
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the keyed ULP nudge core: directed passes over float32 corner
// patterns, then random samples under a series of seeds, with random input
// gaps and output stalls except in one phase. The monitor does the checking.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseItems    = 250;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        seed_we = 1'b0;
  logic [31:0] seed = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] sample_bits = 32'd0;
  logic        last_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] sample_out;
  logic        last_out;
  int          fail_count;
  int          pending;
  int          idle_pct = 15;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  float_sample_keyed_ulp_nudge_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .seed_we_i    (seed_we),
    .seed_i       (seed),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .sample_bits_i(sample_bits),
    .last_in_i    (last_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .sample_out_o (sample_out),
    .last_out_o   (last_out)
  );

  nudge_monitor mon (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .seed_we_i    (seed_we),
    .seed_i       (seed),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .sample_bits_i(sample_bits),
    .last_in_i    (last_in),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .sample_out_i (sample_out),
    .last_out_i   (last_out),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL float_sample_keyed_ulp_nudge_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic [31:0] bits, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    sample_bits <= bits;
    last_in     <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    drain();
    seed_we <= 1'b1;
    seed    <= value;
    @(posedge clk);
    seed_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_sample();
    logic [31:0] r;
    logic [7:0]  e;
    logic [22:0] m;
    r = $urandom;
    e = r[30:23];
    m = r[22:0];
    case ($urandom_range(11))
      0: e = 8'h00;
      1: e = 8'hFF;
      2: e = $urandom_range(1) ? 8'h01 : 8'hFE;
      3: m = 23'($urandom_range(3));
      4: m = 23'h7F_FFFF - 23'($urandom_range(3));
      5: ;
      default: if (e == 8'h00 || e == 8'hFF) e = 8'h80 ^ r[7:0];
    endcase
    if (e == 8'h00 && r[3:0] == 4'd0) e = 8'h80;
    return {r[31], e, m};
  endfunction

  initial begin
    logic [31:0] corners [$];
    logic [31:0] phase_seeds [$];
    corners = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
                32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7FFF_FFFF,
                32'h3F80_0000, 32'h3F80_0001, 32'h3F80_0002, 32'h3F80_0003,
                32'h3FFF_FFFC, 32'h3FFF_FFFD, 32'h3FFF_FFFE, 32'h3FFF_FFFF,
                32'h0080_0002, 32'h7F7F_FFFD, 32'hBF40_0000, 32'hFFFF_FFFF,
                32'h1234_5678, 32'hC2A5_5A5A};
    phase_seeds = '{32'h0000_0001, $urandom, 32'h8000_0000, $urandom, $urandom,
                    32'hFFFF_FFFF, 32'h0000_0000};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset seed is zero: corners must pass untouched
    foreach (corners[i]) send_sample(corners[i], i[0]);
    write_seed(32'hFFFF_FFFF);
    foreach (corners[i]) send_sample(corners[i], ~i[0]);

    foreach (phase_seeds[p]) begin
      write_seed(phase_seeds[p]);
      idle_pct = (p == 3) ? 0 : 15;
      for (int n = 0; n < PhaseItems; n++) begin
        send_sample(pick_sample(), ($urandom_range(15) == 0));
      end
    end
    idle_pct = 15;

    drain();
    repeat (fskun_pkg::NumStages + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS float_sample_keyed_ulp_nudge_core");
    end else begin
      $display("FAIL float_sample_keyed_ulp_nudge_core");
    end
    $finish;
  end

endmodule
